// ----- hdl/bls_pkg.sv -----
// ----------------------------------------------------------------------------
// bls_pkg
// shared request codes and controller/datapath command types for the stack
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned OpWidth   = 2;

  // request kinds
  localparam logic [OpWidth-1:0] OP_PUSH = 2'd0;
  localparam logic [OpWidth-1:0] OP_POP  = 2'd1;
  localparam logic [OpWidth-1:0] OP_PEEK = 2'd2;
  localparam logic [OpWidth-1:0] OP_BAD  = 2'd3;

  // what the output register takes in this cycle
  typedef enum logic [1:0] {
    LD_NONE,
    LD_ERR,
    LD_PUSH,
    LD_READ
  } load_sel_e;

  typedef struct packed {
    logic      push;    // write top entry, bump fill level
    logic      read;    // start a ram read of the top entry
    logic      pop;     // drop the fill level by one
    load_sel_e load;
  } bls_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } bls_stat_t;

endpackage

// ----- hdl/bls_req_if.sv -----
// ----------------------------------------------------------------------------
// bls_req_if
// request channel of the stack: request kind and push word
// ----------------------------------------------------------------------------
interface bls_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

// ----- hdl/bls_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bls_rsp_if
// result channel of the stack: status, read word and empty flag
// ----------------------------------------------------------------------------
interface bls_rsp_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [31:0] read_value;
  logic               now_empty;

  modport source (output valid, output status, output read_value, output now_empty,
                  input ready);
  modport sink   (input valid, input status, input read_value, input now_empty,
                  output ready);
endinterface

// ----- hdl/bls_ram.sv -----
// ----------------------------------------------------------------------------
// bls_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/bls_ctrl.sv -----
// ----------------------------------------------------------------------------
// bls_ctrl
// request sequencer: decodes each request and steers the datapath
// ----------------------------------------------------------------------------
module bls_ctrl
  import bls_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [OpWidth-1:0] in_op_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  bls_stat_t          stat_i,
  output bls_cmd_t           cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic     state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     accept;
  bls_cmd_t cmd;

  // in idle, free to take a request once the result register is empty or draining
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    cmd      = '0;
    cmd.load = LD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            OP_PUSH: begin
              if (!stat_i.full) begin
                cmd.push = 1'b1;
                cmd.load = LD_PUSH;
              end else begin
                cmd.load = LD_ERR;
              end
            end
            OP_POP: begin
              if (!stat_i.empty) begin
                cmd.read = 1'b1;
                cmd.pop  = 1'b1;
                state_d  = ST_READ;
              end else begin
                cmd.load = LD_ERR;
              end
            end
            OP_PEEK: begin
              if (!stat_i.empty) begin
                cmd.read = 1'b1;
                state_d  = ST_READ;
              end else begin
                cmd.load = LD_ERR;
              end
            end
            default: begin
              cmd.load = LD_ERR;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.load = LD_READ;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load != LD_NONE) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ----- hdl/bls_datapath.sv -----
// ----------------------------------------------------------------------------
// bls_datapath
// fill level, entry ram and result register of the stack
// ----------------------------------------------------------------------------
module bls_datapath
  import bls_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bls_cmd_t                    cmd_i,
  input  logic signed [WordWidth-1:0] push_value_i,
  output bls_stat_t                   stat_o,
  output logic                        status_o,
  output logic signed [WordWidth-1:0] read_value_o,
  output logic                        now_empty_o
);

  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [FW-1:0] FillMax = FW'(DEPTH);

  logic [FW-1:0]                fill_q, fill_d;
  logic [FW-1:0]                top_idx;
  logic [WordWidth-1:0]         rdata;
  logic                         status_q, status_d;
  logic signed [WordWidth-1:0]  read_value_q, read_value_d;
  logic                         now_empty_q, now_empty_d;

  assign stat_o.empty = (fill_q == '0);
  assign stat_o.full  = (fill_q == FillMax);
  assign top_idx      = fill_q - FW'(1);

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.push) begin
      fill_d = fill_q + FW'(1);
    end else if (cmd_i.pop) begin
      fill_d = top_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  bls_ram #(
    .WIDTH (WordWidth),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (push_value_i),
    .re_i    (cmd_i.read),
    .raddr_i (top_idx[AW-1:0]),
    .rdata_o (rdata)
  );

  // result register, payload only
  always_comb begin
    status_d     = status_q;
    read_value_d = read_value_q;
    now_empty_d  = now_empty_q;
    unique case (cmd_i.load)
      LD_ERR: begin
        status_d     = 1'b1;
        read_value_d = '0;
        now_empty_d  = stat_o.empty;
      end
      LD_PUSH: begin
        status_d     = 1'b0;
        read_value_d = '0;
        now_empty_d  = 1'b0;
      end
      LD_READ: begin
        status_d     = 1'b0;
        read_value_d = rdata;
        now_empty_d  = stat_o.empty;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    read_value_q <= read_value_d;
    now_empty_q  <= now_empty_d;
  end

  assign status_o     = status_q;
  assign read_value_o = read_value_q;
  assign now_empty_o  = now_empty_q;

endmodule

// ----- hdl/bounded_lifo_stack.sv -----
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// last-in-first-out stack of up to DEPTH signed 32-bit words
// ----------------------------------------------------------------------------
// Each request on req_i is a push, a pop or a peek of the top word, and each
// gives exactly one result on rsp_o: status (0 done, 1 error), read_value
// (word popped or peeked, 0 on push and on error) and now_empty (the stack
// holds nothing after the request). A push on a full stack, a pop or peek on
// an empty stack and the unused request code 3 are errors and leave the stack
// as it was. A push or an error loads the result register directly, so those
// requests can follow each other every cycle while the sink takes each result;
// a pop or a peek passes a read state first, as the entry ram has registered
// read data. The result sits in an output register; the next request is taken
// in the same cycle the current result is taken by the sink. After reset the
// stack is empty, with no clearing pass needed: only written entries are read.
// ----------------------------------------------------------------------------
module bounded_lifo_stack
  import bls_pkg::*;
#(
  parameter int unsigned DEPTH = 128   // 2 .. 4096 entries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bls_req_if.sink   req_i,
  bls_rsp_if.source rsp_o
);

  // command and status between sequencer and datapath
  bls_cmd_t  cmd;
  bls_stat_t stat;

  // sequencer: decodes the request against full/empty, owns result valid
  bls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.op),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: fill level, entry ram and result payload
  bls_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .push_value_i (req_i.push_value),
    .stat_o       (stat),
    .status_o     (rsp_o.status),
    .read_value_o (rsp_o.read_value),
    .now_empty_o  (rsp_o.now_empty)
  );

endmodule
